/* hdl/bcdf_pkg.sv */
// Shared constants, codes and transaction types for the binary constraint domain filter.
package bcdf_pkg;

	localparam int DATA_W      = 64;
	localparam int DOMAIN_SIZE = 64;
	localparam int IDX_W       = $clog2(DOMAIN_SIZE);
	localparam int OP_W        = 3;
	localparam int CONST_W     = 6;
	localparam int STATUS_W    = 2;

	localparam logic [DATA_W-1:0] DOM_MASK = DATA_W'({DOMAIN_SIZE{1'b1}});

	localparam logic [OP_W-1:0] OP_LT   = 3'd0;
	localparam logic [OP_W-1:0] OP_LEQ  = 3'd1;
	localparam logic [OP_W-1:0] OP_EQ   = 3'd2;
	localparam logic [OP_W-1:0] OP_NEQ  = 3'd3;
	localparam logic [OP_W-1:0] OP_EQC  = 3'd4;
	localparam logic [OP_W-1:0] OP_NEQC = 3'd5;

	localparam logic [STATUS_W-1:0] ST_UNPRUNED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRUNED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAILURE  = 2'd2;

	typedef logic [DOMAIN_SIZE-1:0] dom_t;
	typedef logic [IDX_W-1:0]       idx_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic               target;
		dom_t               x_dom;
		dom_t               y_dom;
		logic [CONST_W-1:0] cval;
	} item_t;

	typedef struct packed {
		dom_t                dom;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

/* hdl/bcdf_filter.sv */
// Combinational domain filter: bound and membership pruning for one constraint.
module bcdf_filter (
	input  bcdf_pkg::item_t   item,
	output bcdf_pkg::result_t res
);
	import bcdf_pkg::*;

	function automatic idx_t low_bit(input dom_t v);
		idx_t r;
		r = '0;
		for (int i = DOMAIN_SIZE - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	function automatic idx_t high_bit(input dom_t v);
		idx_t r;
		r = '0;
		for (int i = 0; i < DOMAIN_SIZE; i++) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	function automatic dom_t below(input idx_t p);
		dom_t r;
		for (int i = 0; i < DOMAIN_SIZE; i++) r[i] = (IDX_W'(i) < p);
		return r;
	endfunction

	function automatic dom_t above(input idx_t p);
		dom_t r;
		for (int i = 0; i < DOMAIN_SIZE; i++) r[i] = (IDX_W'(i) > p);
		return r;
	endfunction

	dom_t d, o, cbit, k, nd_neq, nd_neqc, nd_bound;
	idx_t xmin, xmax, ymin, ymax;
	logic unary, strict, o_one;
	logic b_unpruned, b_fail;

	always_comb begin
		unary = (item.op == OP_EQC) || (item.op == OP_NEQC);
		d     = (!unary && item.target) ? item.y_dom : item.x_dom;
		o     = unary ? '0 : (item.target ? item.x_dom : item.y_dom);
		cbit  = '0;
		if (32'(item.cval) < DOMAIN_SIZE) cbit[IDX_W'(item.cval)] = 1'b1;

		xmin = low_bit(item.x_dom);
		xmax = high_bit(item.x_dom);
		ymin = low_bit(item.y_dom);
		ymax = high_bit(item.y_dom);
		strict = (item.op == OP_LT);

		if (!item.target) begin
			b_unpruned = strict ? (xmax < ymax) : (xmax <= ymax);
			b_fail     = strict ? (xmin >= ymax) : (xmin > ymax);
			nd_bound   = item.x_dom & (strict ? below(ymax) : ~above(ymax));
		end else begin
			b_unpruned = strict ? (xmin < ymin) : (xmin <= ymin);
			b_fail     = strict ? (xmin >= ymax) : (xmin > ymax);
			nd_bound   = item.y_dom & (strict ? above(xmin) : ~below(xmin));
		end

		k       = d & o;
		o_one   = (o != '0) && ((o & (o - dom_t'(1))) == '0);
		nd_neq  = d & ~o;
		nd_neqc = d & ~cbit;

		res.dom    = d;
		res.status = ST_UNPRUNED;
		if (item.op > OP_NEQC) begin
			res.dom = item.x_dom;
		end else if (d == '0) begin
			res.status = ST_FAILURE;
		end else if (item.op <= OP_EQ && o == '0) begin
			res.status = ST_FAILURE;
		end else begin
			case (item.op)
				OP_LT, OP_LEQ: begin
					if (b_unpruned) begin
						res.status = ST_UNPRUNED;
					end else if (b_fail) begin
						res.status = ST_FAILURE;
					end else begin
						res.dom    = nd_bound;
						res.status = ST_PRUNED;
					end
				end
				OP_EQ: begin
					if (k == d) begin
						res.status = ST_UNPRUNED;
					end else if (k == '0) begin
						res.status = ST_FAILURE;
					end else begin
						res.dom    = k;
						res.status = ST_PRUNED;
					end
				end
				OP_NEQ: begin
					if (o_one && k != '0) begin
						res.dom    = nd_neq;
						res.status = (nd_neq == '0) ? ST_FAILURE : ST_PRUNED;
					end
				end
				OP_EQC: begin
					if ((d & cbit) == '0) begin
						res.dom    = '0;
						res.status = ST_FAILURE;
					end else if (d != cbit) begin
						res.dom    = cbit;
						res.status = ST_PRUNED;
					end
				end
				default: begin
					if ((d & cbit) != '0) begin
						res.dom    = nd_neqc;
						res.status = (nd_neqc == '0) ? ST_FAILURE : ST_PRUNED;
					end
				end
			endcase
		end
	end

endmodule

/* hdl/binary_constraint_domain_filter.sv */
// Top level of the binary constraint domain filter: input register, filter, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  request | req_valid, req_stall | op, target, x_domain, y_domain, const_value
//  result  | rsp_valid, rsp_stall | pruned_domain, status
//
// One transaction per cycle while rsp_stall is low; each result is registered in the
// input register and then in the result register around the filter.
// Reset clears both stage valid flags; no clearing pass is needed.
// A stalled result holds the result register; the input register keeps accepting
// while it is empty or drains into the result register.
module binary_constraint_domain_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [bcdf_pkg::OP_W-1:0]       op,
	input  logic                            target,
	input  logic [bcdf_pkg::DATA_W-1:0]     x_domain,
	input  logic [bcdf_pkg::DATA_W-1:0]     y_domain,
	input  logic [bcdf_pkg::CONST_W-1:0]    const_value,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [bcdf_pkg::DATA_W-1:0]     pruned_domain,
	output logic [bcdf_pkg::STATUS_W-1:0]   status
);
	import bcdf_pkg::*;

	item_t   item_s1;
	result_t res_c;
	result_t res_s2;
	logic    valid_s1, valid_s2;
	logic    req_take, adv_s2, rsp_take;

	assign rsp_take  = valid_s2 && !rsp_stall;
	assign adv_s2    = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s2;
	assign req_take  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_take) valid_s1 <= 1'b1;
			else if (adv_s2) valid_s1 <= 1'b0;
			if (adv_s2) valid_s2 <= 1'b1;
			else if (rsp_take) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1.op     <= op;
			item_s1.target <= target;
			item_s1.x_dom  <= x_domain[DOMAIN_SIZE-1:0];
			item_s1.y_dom  <= y_domain[DOMAIN_SIZE-1:0];
			item_s1.cval   <= const_value;
		end
		if (adv_s2) res_s2 <= res_c;
	end

	bcdf_filter u_filter (
		.item (item_s1),
		.res  (res_c)
	);

	assign rsp_valid     = valid_s2;
	assign pruned_domain = DATA_W'(res_s2.dom);
	assign status        = res_s2.status;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a waiting transaction");

	a_pruned_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_PRUNED |-> pruned_domain != '0)
		else $error("pruned result with empty domain");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pruned_domain & ~DOM_MASK) == '0)
		else $error("result domain has bits beyond the domain size");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && valid_s2 && rsp_stall)
		else $error("request stalled with room in the pipeline");

endmodule

/* bench/bcdf_checker.sv */
// Checker for the binary constraint domain filter: watches both channels, predicts and compares.
module bcdf_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  logic [bcdf_pkg::OP_W-1:0]       op,
	input  logic                            target,
	input  logic [bcdf_pkg::DATA_W-1:0]     x_domain,
	input  logic [bcdf_pkg::DATA_W-1:0]     y_domain,
	input  logic [bcdf_pkg::CONST_W-1:0]    const_value,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  logic [bcdf_pkg::DATA_W-1:0]     pruned_domain,
	input  logic [bcdf_pkg::STATUS_W-1:0]   status,
	output int                              fail_count,
	output int                              pending
);
	import bcdf_pkg::*;

	result_t pending_results[$];
	result_t oldest;

	function automatic int lowest_value(input dom_t v);
		for (int i = 0; i < DOMAIN_SIZE; i++)
			if (v[i]) return i;
		return DOMAIN_SIZE - 1;
	endfunction

	function automatic int highest_value(input dom_t v);
		for (int i = DOMAIN_SIZE - 1; i >= 0; i--)
			if (v[i]) return i;
		return 0;
	endfunction

	function automatic dom_t mask_below(input int p);
		return (dom_t'(1) << p) - dom_t'(1);
	endfunction

	function automatic dom_t mask_above(input int p);
		if (p >= DOMAIN_SIZE - 1) return '0;
		return ~dom_t'(0) << (p + 1);
	endfunction

	function automatic result_t filter_domain(
		input logic [OP_W-1:0]    kind,
		input logic               tgt,
		input logic [DATA_W-1:0]  x_in,
		input logic [DATA_W-1:0]  y_in,
		input logic [CONST_W-1:0] c
	);
		dom_t                xd, yd, d, o, nd, cbit, k;
		logic [STATUS_W-1:0] st;
		int                  xmin, xmax, ymin, ymax;
		bit                  strict;
		result_t             r;
		xd   = x_in & DOM_MASK;
		yd   = y_in & DOM_MASK;
		cbit = (int'(c) < DOMAIN_SIZE) ? (dom_t'(1) << c) : '0;
		if (kind > OP_NEQ) begin
			d = xd;
			o = '0;
		end else begin
			d = tgt ? yd : xd;
			o = tgt ? xd : yd;
		end
		nd = d;
		st = ST_UNPRUNED;
		if (kind > OP_NEQC) begin
			nd = xd;
		end else if (d == '0) begin
			st = ST_FAILURE;
		end else if (kind <= OP_EQ && o == '0) begin
			st = ST_FAILURE;
		end else if (kind == OP_LT || kind == OP_LEQ) begin
			xmin   = lowest_value(xd);
			xmax   = highest_value(xd);
			ymin   = lowest_value(yd);
			ymax   = highest_value(yd);
			strict = (kind == OP_LT);
			if (!tgt) begin
				if (strict ? (xmax < ymax) : (xmax <= ymax)) begin
					st = ST_UNPRUNED;
				end else if (strict ? (xmin >= ymax) : (xmin > ymax)) begin
					st = ST_FAILURE;
				end else begin
					nd = xd & (strict ? mask_below(ymax) : ~mask_above(ymax));
					st = ST_PRUNED;
				end
			end else begin
				if (strict ? (xmin < ymin) : (xmin <= ymin)) begin
					st = ST_UNPRUNED;
				end else if (strict ? (xmin >= ymax) : (xmin > ymax)) begin
					st = ST_FAILURE;
				end else begin
					nd = yd & (strict ? mask_above(xmin) : ~mask_below(xmin));
					st = ST_PRUNED;
				end
			end
		end else if (kind == OP_EQ) begin
			k = d & o;
			if (k == d) begin
				st = ST_UNPRUNED;
			end else if (k == '0) begin
				st = ST_FAILURE;
			end else begin
				nd = k;
				st = ST_PRUNED;
			end
		end else if (kind == OP_NEQ) begin
			if ($countones(o) == 1 && (d & o) != '0) begin
				nd = d & ~o;
				st = (nd == '0) ? ST_FAILURE : ST_PRUNED;
			end
		end else if (kind == OP_EQC) begin
			if ((d & cbit) == '0) begin
				nd = '0;
				st = ST_FAILURE;
			end else if (d == cbit) begin
				st = ST_UNPRUNED;
			end else begin
				nd = cbit;
				st = ST_PRUNED;
			end
		end else begin
			if ((d & cbit) != '0) begin
				nd = d & ~cbit;
				st = (nd == '0) ? ST_FAILURE : ST_PRUNED;
			end
		end
		r.dom    = nd & DOM_MASK;
		r.status = st;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", pruned_domain, '0);
				end else begin
					oldest = pending_results.pop_front();
					if (pruned_domain !== oldest.dom)
						report_mismatch("pruned_domain", pruned_domain, oldest.dom);
					if (status !== oldest.status)
						report_mismatch("status", DATA_W'(status), DATA_W'(oldest.status));
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(filter_domain(op, target, x_domain, y_domain,
					const_value));
			pending <= pending_results.size();
		end
	end

endmodule

/* bench/tb_binary_constraint_domain_filter.sv */
// Testbench top for the binary constraint domain filter: clock, reset, stimulus and verdict.
module tb_binary_constraint_domain_filter;
	import bcdf_pkg::*;

	localparam int CYCLE_LIMIT = 60000;
	localparam int HOLD_CYCLES = 60;
	localparam int RANDOM_ITEMS = 400;
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [OP_W-1:0]     op;
	logic                target;
	logic [DATA_W-1:0]   x_domain;
	logic [DATA_W-1:0]   y_domain;
	logic [CONST_W-1:0]  const_value;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [DATA_W-1:0]   pruned_domain;
	logic [STATUS_W-1:0] status;

	int fail_count;
	int pending;
	int cycle_count;
	bit sender_idle_on;
	bit sink_idle_on;
	bit hold_armed;
	bit hold_done;

	binary_constraint_domain_filter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.op            (op),
		.target        (target),
		.x_domain      (x_domain),
		.y_domain      (y_domain),
		.const_value   (const_value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.pruned_domain (pruned_domain),
		.status        (status)
	);

	bcdf_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.op            (op),
		.target        (target),
		.x_domain      (x_domain),
		.y_domain      (y_domain),
		.const_value   (const_value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.pruned_domain (pruned_domain),
		.status        (status),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off
	initial begin
		rsp_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				rsp_stall <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] kind, input logic tgt, input dom_t xd,
			input dom_t yd, input logic [CONST_W-1:0] c);
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid   <= 1'b1;
		op          <= kind;
		target      <= tgt;
		x_domain    <= xd;
		y_domain    <= yd;
		const_value <= c;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int pick_member(input dom_t v);
		int s;
		s = $urandom_range(0, DOMAIN_SIZE - 1);
		for (int k = 0; k < DOMAIN_SIZE; k++)
			if (v[(s + k) % DOMAIN_SIZE]) return (s + k) % DOMAIN_SIZE;
		return s;
	endfunction

	function automatic dom_t random_domain();
		int lo, hi;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return dom_t'(1) << $urandom_range(0, DOMAIN_SIZE - 1);
			2: return ~dom_t'(0);
			3: begin
				lo = $urandom_range(0, DOMAIN_SIZE - 1);
				hi = $urandom_range(lo, DOMAIN_SIZE - 1);
				return (~dom_t'(0) << lo) & (~dom_t'(0) >> (DOMAIN_SIZE - 1 - hi));
			end
			4: return {$urandom(), $urandom()} & {$urandom(), $urandom()}
				& {$urandom(), $urandom()};
			5: return (dom_t'(1) << $urandom_range(0, DOMAIN_SIZE - 1))
				| (dom_t'(1) << $urandom_range(0, DOMAIN_SIZE - 1));
			6: return ~(dom_t'(1) << $urandom_range(0, DOMAIN_SIZE - 1));
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic send_random_item();
		logic [OP_W-1:0]    kind;
		logic               tgt;
		dom_t               xd, yd;
		logic [CONST_W-1:0] c;
		if ($urandom_range(0, 19) == 0)
			kind = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		else
			kind = OP_W'($urandom_range(OP_LT, OP_NEQC));
		tgt = 1'($urandom_range(0, 1));
		xd  = random_domain();
		case ($urandom_range(0, 3))
			0: yd = xd & random_domain();
			1: yd = (xd != '0) ? (dom_t'(1) << pick_member(xd)) : random_domain();
			2: yd = xd | random_domain();
			default: yd = random_domain();
		endcase
		if ($urandom_range(0, 1) && xd != '0)
			c = CONST_W'(pick_member(xd));
		else
			c = CONST_W'($urandom_range(0, DOMAIN_SIZE - 1));
		send_item(kind, tgt, xd, yd, c);
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		op             = OP_LT;
		target         = 1'b0;
		x_domain       = '0;
		y_domain       = '0;
		const_value    = '0;
		sender_idle_on = 1'b1;
		sink_idle_on   = 1'b1;
		hold_armed     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_LT,   1'b0, ~dom_t'(0), ~dom_t'(0), '0);
		send_item(OP_LT,   1'b1, 64'h1, ~dom_t'(0), '0);
		send_item(OP_LT,   1'b0, '0, ~dom_t'(0), '0);
		send_item(OP_LT,   1'b0, 64'hff, '0, '0);
		send_item(OP_LT,   1'b0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
		send_item(OP_LT,   1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, '0);
		send_item(OP_LEQ,  1'b0, 64'h7e0, 64'h10_0000, '0);
		send_item(OP_LEQ,  1'b1, 64'h4000_0000, ~dom_t'(0), '0);
		send_item(OP_LEQ,  1'b0, 64'h100_0000_0000, 64'h8, '0);
		send_item(OP_LEQ,  1'b1, 64'hf0, 64'hff00, '0);
		send_item(OP_EQ,   1'b0, 64'h5a5a_0000_ffff_1234, 64'h5a5a_0000_ffff_1234, '0);
		send_item(OP_EQ,   1'b1, 64'h0f0f, 64'hf0f0, '0);
		send_item(OP_EQ,   1'b0, ~dom_t'(0), 64'h8000_0000_0000_0001, '0);
		send_item(OP_EQ,   1'b1, '0, 64'h3, '0);
		send_item(OP_NEQ,  1'b0, 64'h80, 64'h80, '0);
		send_item(OP_NEQ,  1'b0, ~dom_t'(0), 64'h80, '0);
		send_item(OP_NEQ,  1'b0, 64'hf, '0, '0);
		send_item(OP_NEQ,  1'b0, 64'hf, 64'h3, '0);
		send_item(OP_NEQ,  1'b1, 64'h1, 64'h3, '0);
		send_item(OP_EQC,  1'b1, ~dom_t'(0), '0, 6'd0);
		send_item(OP_EQC,  1'b0, 64'h8000_0000_0000_0000, ~dom_t'(0), 6'd63);
		send_item(OP_EQC,  1'b0, 64'h0ff0, '0, 6'd2);
		send_item(OP_EQC,  1'b0, '0, '0, 6'd5);
		send_item(OP_NEQC, 1'b0, ~dom_t'(0), '0, 6'd63);
		send_item(OP_NEQC, 1'b1, 64'h20, 64'h20, 6'd5);
		send_item(OP_NEQC, 1'b0, 64'hff00, '0, 6'd3);
		send_item(OP_UNDEF_LO, 1'b1, {$urandom(), $urandom()}, {$urandom(), $urandom()},
			CONST_W'($urandom_range(0, DOMAIN_SIZE - 1)));
		send_item(OP_UNDEF_HI, 1'b0, ~dom_t'(0), '0, 6'd63);

		// pause the sender until every result is back
		drain_results();
		hold_armed <= 1'b1;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) begin
				sender_idle_on <= (i < 320) && ((i / 50) % 2 == 0 || $urandom_range(0, 1));
				sink_idle_on   <= (i < 320) && ((i / 50) % 2 == 0 || $urandom_range(0, 1));
			end
			if (i == 200)
				drain_results();
			send_random_item();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
